// ===== rtl/core/shfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shfp_pkg
// Types and constants shared by the sync header frame parser.
// ----------------------------------------------------------------------------
package shfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hA5;
  localparam logic [7:0] CMD_TEXT  = 8'h01;
  localparam logic       ACK_OK    = 1'b0;
  localparam logic       ACK_FAIL  = 1'b1;

  typedef struct packed {
    logic [7:0] byte_position;
    logic [7:0] frame_length;
    logic [7:0] command_code;
  } shfp_state_t;

  typedef struct packed {
    logic       text_valid;
    logic [7:0] text_byte;
    logic [6:0] text_index;
    logic       ack_valid;
    logic       ack_code;
    logic       frame_commit;
    logic [6:0] text_length;
  } shfp_result_t;

endpackage : shfp_pkg
`default_nettype wire

// ===== rtl/core/shfp_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shfp_decode
// Per-byte frame decode: next parser state and the result for one byte.
// ----------------------------------------------------------------------------
module shfp_decode
  import shfp_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  wire shfp_state_t  state_i,
  input  wire logic [7:0]   rx_byte_i,
  output shfp_state_t       state_nxt_o,
  output shfp_result_t      result_o
);

  localparam logic [8:0] DEPTH_W = 9'(BUF_DEPTH);

  logic [7:0] pos;
  logic [8:0] last;
  logic [7:0] cmd;
  logic [8:0] len_plus3;
  logic [7:0] idx;
  logic [7:0] tlen;

  always_comb begin
    pos         = state_i.byte_position;
    last        = {1'b0, state_i.frame_length} + 9'd2;
    cmd         = (pos == 8'd3) ? rx_byte_i : state_i.command_code;
    len_plus3   = {1'b0, rx_byte_i} + 9'd3;
    idx         = pos - 8'd4;
    tlen        = (state_i.frame_length >= 8'd2) ? (state_i.frame_length - 8'd2) : 8'd0;
    state_nxt_o = state_i;
    result_o    = '0;
    case (pos)
      8'd0: begin
        state_nxt_o.byte_position = (rx_byte_i == SYNC_BYTE) ? 8'd1 : 8'd0;
      end
      8'd1: begin
        state_nxt_o.byte_position = (rx_byte_i == SYNC_BYTE) ? 8'd2 : 8'd0;
      end
      8'd2: begin
        state_nxt_o.frame_length = rx_byte_i;
        if (rx_byte_i == 8'd0 || len_plus3 > DEPTH_W) begin
          result_o.ack_valid        = 1'b1;
          result_o.ack_code         = ACK_FAIL;
          state_nxt_o.byte_position = 8'd0;
        end else begin
          state_nxt_o.byte_position = 8'd3;
        end
      end
      default: begin
        state_nxt_o.command_code = cmd;
        if ({1'b0, pos} >= last) begin
          if (cmd == CMD_TEXT) begin
            result_o.frame_commit = 1'b1;
            result_o.text_length  = tlen[6:0];
            result_o.ack_valid    = 1'b1;
            result_o.ack_code     = ACK_OK;
          end
          state_nxt_o.byte_position = 8'd0;
        end else begin
          if (pos >= 8'd4 && cmd == CMD_TEXT) begin
            result_o.text_valid = 1'b1;
            result_o.text_byte  = rx_byte_i;
            result_o.text_index = idx[6:0];
          end
          state_nxt_o.byte_position = pos + 8'd1;
        end
      end
    endcase
  end

endmodule : shfp_decode
`default_nettype wire

// ===== rtl/core/sync_header_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_frame_parser
// Parses A5 A5 / length / command / payload / check frames one byte at a time.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_rx_byte
//   out_     output     out_valid / out_ready text, acknowledge and commit
//
// One result per byte, registered; a byte is taken every cycle unless the output stalls.
// The result is valid in the cycle after its input transfer.
// in_ready is high while the result register is empty or being drained.
// Reset returns the parser to header hunting and empties the result register.
// ----------------------------------------------------------------------------
module sync_header_frame_parser
  import shfp_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_text_valid,
  output logic [7:0]      out_text_byte,
  output logic [6:0]      out_text_index,
  output logic            out_ack_valid,
  output logic            out_ack_code,
  output logic            out_frame_commit,
  output logic [6:0]      out_text_length
);

  shfp_state_t  state_r;
  shfp_state_t  state_nxt;
  shfp_result_t result_r;
  shfp_result_t result_nxt;
  logic         out_valid_r;
  logic         in_xfer;

  shfp_decode #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_decode (
    .state_i     (state_r),
    .rx_byte_i   (in_rx_byte),
    .state_nxt_o (state_nxt),
    .result_o    (result_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_text_valid   = result_r.text_valid;
  assign out_text_byte    = result_r.text_byte;
  assign out_text_index   = result_r.text_index;
  assign out_ack_valid    = result_r.ack_valid;
  assign out_ack_code     = result_r.ack_code;
  assign out_frame_commit = result_r.frame_commit;
  assign out_text_length  = result_r.text_length;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("result register not filled after input transfer");

  a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.frame_commit |-> result_r.ack_valid && result_r.ack_code == ACK_OK)
    else $error("commit without success acknowledge");

  a_text_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.text_valid |-> !result_r.ack_valid && !result_r.frame_commit)
    else $error("text byte and acknowledge in one result");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, state_r.byte_position} < 9'(BUF_DEPTH))
    else $error("frame position beyond buffer depth");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(state_r))
    else $error("parser state moved without input transfer");

endmodule : sync_header_frame_parser
`default_nettype wire

// ===== tb/sync_header_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_parser_tb
// Feeds the parser directed frames (bad headers, zero and overrunning lengths,
// lengths one and two, payload extremes), then mostly well-formed frames of
// random size, command and content mixed with noise and broken headers. Both
// channels idle at random and the result side holds off once long enough to
// stall the input. Every result is checked against a cycle-free frame tracker.
// ----------------------------------------------------------------------------
module sync_header_frame_parser_tb;
  import shfp_pkg::*;

  localparam int DEPTH       = 128;
  localparam int CYCLE_LIMIT = 600000;

  class frame_tracker;
    shfp_result_t expected_results[$];
    int           fail_count;
    int           checked_count;
    int           depth;
    logic [7:0]   position;
    logic [7:0]   frame_len;
    logic [7:0]   command;

    function new(int buf_depth);
      depth         = buf_depth;
      position      = '0;
      frame_len     = '0;
      command       = '0;
      fail_count    = 0;
      checked_count = 0;
    endfunction

    function void take_rx_byte(logic [7:0] rx);
      shfp_result_t want;
      int           last;
      int           rx_val;
      logic [7:0]   wide;
      want   = '0;
      rx_val = rx;
      if (position == 8'd0) begin
        position = (rx == SYNC_BYTE) ? 8'd1 : 8'd0;
      end else if (position == 8'd1) begin
        position = (rx == SYNC_BYTE) ? 8'd2 : 8'd0;
      end else if (position == 8'd2) begin
        frame_len = rx;
        if (rx == 8'd0 || rx_val + 3 > depth) begin
          want.ack_valid = 1'b1;
          want.ack_code  = ACK_FAIL;
          position       = 8'd0;
        end else begin
          position = 8'd3;
        end
      end else begin
        last = frame_len;
        last = last + 2;
        if (position == 8'd3) command = rx;
        if (int'(position) >= last) begin
          if (command == CMD_TEXT) begin
            wide                = (frame_len >= 8'd2) ? frame_len - 8'd2 : 8'd0;
            want.frame_commit   = 1'b1;
            want.text_length    = wide[6:0];
            want.ack_valid      = 1'b1;
            want.ack_code       = ACK_OK;
          end
          position = 8'd0;
        end else begin
          if (position >= 8'd4 && command == CMD_TEXT) begin
            wide            = position - 8'd4;
            want.text_valid = 1'b1;
            want.text_byte  = rx;
            want.text_index = wide[6:0];
          end
          position = position + 8'd1;
        end
      end
      expected_results.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        fail_count++;
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(shfp_result_t got);
      shfp_result_t want;
      checked_count++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare("text_valid", want.text_valid, got.text_valid);
      compare("text_byte", want.text_byte, got.text_byte);
      compare("text_index", want.text_index, got.text_index);
      compare("ack_valid", want.ack_valid, got.ack_valid);
      compare("ack_code", want.ack_code, got.ack_code);
      compare("frame_commit", want.frame_commit, got.frame_commit);
      compare("text_length", want.text_length, got.text_length);
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [7:0]   in_rx_byte;
  logic         out_valid;
  logic         out_ready;
  logic         out_text_valid;
  logic [7:0]   out_text_byte;
  logic [6:0]   out_text_index;
  logic         out_ack_valid;
  logic         out_ack_code;
  logic         out_frame_commit;
  logic [6:0]   out_text_length;

  frame_tracker tracker;
  shfp_result_t observed;
  int           cycle_count;
  int           frame_bytes;
  logic         sender_calm;
  logic         long_hold_done;

  sync_header_frame_parser #(
    .BUF_DEPTH(DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_text_valid   (out_text_valid),
    .out_text_byte    (out_text_byte),
    .out_text_index   (out_text_index),
    .out_ack_valid    (out_ack_valid),
    .out_ack_code     (out_ack_code),
    .out_frame_commit (out_frame_commit),
    .out_text_length  (out_text_length)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sync_header_frame_parser");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    else if (roll < 88) return $urandom_range(1, 3);
    else if (roll < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // transfer decided from values held just before the edge
  task automatic send_byte(input logic [7:0] rx);
    logic fire;
    int   gap;
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    do begin
      @(negedge clk);
      fire = in_ready;
      @(posedge clk);
    end while (!fire);
    tracker.take_rx_byte(rx);
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int len, input logic [7:0] cmd);
    logic [7:0] len_byte;
    int         i;
    len_byte = len[7:0];
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(len_byte);
    if (len >= 1 && len + 3 <= DEPTH) begin
      send_byte(cmd);
      for (i = 0; i < len - 2; i++) send_byte(8'($urandom_range(0, 255)));
      if (len >= 2) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      observed = {out_text_valid, out_text_byte, out_text_index, out_ack_valid,
                  out_ack_code, out_frame_commit, out_text_length};
      tracker.check_result(observed);
    end
  end

  // result side: ready runs, random stalls and one long hold-off
  initial begin
    int run;
    int stall;
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!long_hold_done && tracker.checked_count >= 200) begin
        long_hold_done = 1'b1;
        stall          = 300;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int         roll;
    int         len;
    logic [7:0] cmd;
    tracker     = new(DEPTH);
    cycle_count = 0;
    frame_bytes = 0;
    sender_calm = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, CMD_TEXT);
    send_frame(DEPTH - 2, CMD_TEXT);
    send_frame(1, CMD_TEXT);
    send_frame(2, CMD_TEXT);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h04);
    send_byte(CMD_TEXT);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);

    while (frame_bytes < 1000) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      roll        = $urandom_range(0, 99);
      if (roll < 70) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) len = DEPTH - 3;
        else if (roll < 10) len = $urandom_range(13, DEPTH - 3);
        else len = $urandom_range(1, 12);
        cmd = ($urandom_range(0, 3) != 0) ? CMD_TEXT : 8'($urandom_range(0, 255));
        send_frame(len, cmd);
        frame_bytes += len + 3;
      end else if (roll < 80) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (roll < 90) begin
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(DEPTH - 2, 255);
        send_frame(len, CMD_TEXT);
      end
    end
    in_valid <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("PASS sync_header_frame_parser");
    end else begin
      $display("FAIL sync_header_frame_parser");
    end
    $finish;
  end

endmodule
